@@ rtl/npc_pkg.sv @@
// shared types and constants for the nearest palette color classifier
package npc_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int IDX_W       = 3;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 24;
  localparam int DIST_W      = 18;
  localparam int Q_W         = 16;
  localparam int CONF_W      = 16;
  localparam int RES_W       = 56;
  localparam int KT_W        = 40;
  localparam int ROOT_STEPS  = 16;

  localparam logic [Q_W-1:0]    FULL_SCALE = 16'h8000;
  localparam logic [DIST_W-1:0] MAX_DIST   = 18'd195075;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [NUM_ENTRIES-1:0][COLOR_W-1:0] palette_t;
  typedef logic [NUM_ENTRIES-1:0][DIST_W-1:0]  dist_vec_t;

  localparam palette_t RESET_PALETTE = {
    24'hFFFFFF, 24'h000000, 24'h19B219, 24'h0000FF,
    24'h800080, 24'hFF0000, 24'hFA8214, 24'hFFFF00
  };

  typedef struct packed {
    logic  en;
    idx_t  idx;
    dist_t sq_dist;
  } cand_t;

  typedef struct packed {
    logic                    valid;
    idx_t                    idx;
    dist_t                   sq_dist;
    logic [Q_W-1:0]          q;
    logic signed [RES_W-1:0] res;
    logic signed [KT_W-1:0]  kt;
  } root_t;

  typedef struct packed {
    idx_t              idx;
    dist_t             sq_dist;
    logic [CONF_W-1:0] conf;
  } result_t;

endpackage

@@ rtl/npc_dist.sv @@
// two stage squared distance from the sample to every palette entry
module npc_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  npc_pkg::palette_t   palette,
  output logic                dist_valid,
  output npc_pkg::dist_vec_t  sq_dist
);

  typedef logic [npc_pkg::NUM_ENTRIES-1:0][2:0][npc_pkg::CHAN_W-1:0] diff_vec_t;

  logic               diff_valid;
  diff_vec_t          diff;
  diff_vec_t          diff_next;
  npc_pkg::dist_vec_t sq_dist_next;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    for (int i = 0; i < npc_pkg::NUM_ENTRIES; i++) begin
      diff_next[i][2] = abs_diff(red,   palette[i][23:16]);
      diff_next[i][1] = abs_diff(green, palette[i][15:8]);
      diff_next[i][0] = abs_diff(blue,  palette[i][7:0]);
    end
  end

  always_comb begin
    for (int i = 0; i < npc_pkg::NUM_ENTRIES; i++) begin
      sq_dist_next[i] = npc_pkg::DIST_W'(16'(diff[i][2]) * 16'(diff[i][2]))
                      + npc_pkg::DIST_W'(16'(diff[i][1]) * 16'(diff[i][1]))
                      + npc_pkg::DIST_W'(16'(diff[i][0]) * 16'(diff[i][0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      dist_valid <= 1'b0;
    end else if (en) begin
      diff_valid <= in_valid;
      dist_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff    <= diff_next;
      sq_dist <= sq_dist_next;
    end
  end

endmodule

@@ rtl/npc_min.sv @@
// registered two stage minimum tree over the palette distances
module npc_min #(
  parameter int PALETTE_SIZE = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               dist_valid,
  input  npc_pkg::dist_vec_t sq_dist,
  output logic               best_valid,
  output npc_pkg::cand_t     best
);

  npc_pkg::cand_t leaf [npc_pkg::NUM_ENTRIES];
  npc_pkg::cand_t lvl1 [4];
  npc_pkg::cand_t lvl2_next [2];
  npc_pkg::cand_t lvl2 [2];
  npc_pkg::cand_t best_next;
  logic           lvl2_valid;

  // lower index is always on side a, so ties keep it
  function automatic npc_pkg::cand_t pick(input npc_pkg::cand_t a, input npc_pkg::cand_t b);
    npc_pkg::cand_t r;
    if (b.en && (!a.en || (b.sq_dist < a.sq_dist))) begin
      r = b;
    end else begin
      r = a;
    end
    r.en = a.en | b.en;
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < npc_pkg::NUM_ENTRIES; i++) begin
      leaf[i].en      = (i < PALETTE_SIZE);
      leaf[i].idx     = npc_pkg::IDX_W'(i);
      leaf[i].sq_dist = sq_dist[i];
    end
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      lvl2_next[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    best_next = pick(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl2_valid <= 1'b0;
      best_valid <= 1'b0;
    end else if (en) begin
      lvl2_valid <= dist_valid;
      best_valid <= lvl2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lvl2[0] <= lvl2_next[0];
      lvl2[1] <= lvl2_next[1];
      best    <= best_next;
    end
  end

endmodule

@@ rtl/npc_root.sv @@
// pipelined digit recurrence for the rounded scaled square root, one bit a stage
module npc_root (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           best_valid,
  input  npc_pkg::cand_t best,
  output npc_pkg::root_t root
);

  localparam int RES_W = npc_pkg::RES_W;
  localparam int KT_W  = npc_pkg::KT_W;
  localparam int STEPS = npc_pkg::ROOT_STEPS;

  localparam logic signed [RES_W-1:0] K_RES = RES_W'(npc_pkg::MAX_DIST);
  localparam logic signed [KT_W-1:0]  K_KT  = KT_W'(npc_pkg::MAX_DIST);

  npc_pkg::root_t st [STEPS+1];
  npc_pkg::root_t init_next;

  // res holds dist*2^32 - t*t*k with t = 2q-1, kt holds t*k
  always_comb begin
    init_next.valid   = best_valid;
    init_next.idx     = best.idx;
    init_next.sq_dist = best.sq_dist;
    init_next.q       = '0;
    init_next.res     = $signed(RES_W'({best.sq_dist, 32'd0})) - K_RES;
    init_next.kt      = -K_KT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= init_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].idx     <= init_next.idx;
      st[0].sq_dist <= init_next.sq_dist;
      st[0].q       <= init_next.q;
      st[0].res     <= init_next.res;
      st[0].kt      <= init_next.kt;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int J = STEPS - 1 - s;

    logic signed [RES_W-1:0] trial;
    npc_pkg::root_t          nxt;

    // growing t by 2b adds k*(4bt + 4b^2) to t*t*k
    assign trial = st[s].res
                 - (RES_W'(st[s].kt) <<< (J + 2))
                 - (K_RES <<< (2 * J + 2));

    always_comb begin
      nxt = st[s];
      if (!trial[RES_W-1]) begin
        nxt.res = trial;
        nxt.q   = st[s].q | (npc_pkg::Q_W'(1) << J);
        nxt.kt  = st[s].kt + (K_KT <<< (J + 1));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[s+1].valid <= 1'b0;
      end else if (en) begin
        st[s+1].valid <= nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s+1].idx     <= nxt.idx;
        st[s+1].sq_dist <= nxt.sq_dist;
        st[s+1].q       <= nxt.q;
        st[s+1].res     <= nxt.res;
        st[s+1].kt      <= nxt.kt;
      end
    end
  end

  assign root = st[STEPS];

endmodule

@@ rtl/npc_out.sv @@
// output register with a one word skid stage and the confidence subtract
module npc_out (
  input  logic                        clk,
  input  logic                        rst,
  input  npc_pkg::root_t              root,
  input  logic                        out_stall,
  output logic                        en,
  output logic                        out_valid,
  output logic [npc_pkg::IDX_W-1:0]   match_index,
  output logic [npc_pkg::DIST_W-1:0]  min_distance_squared,
  output logic [npc_pkg::CONF_W-1:0]  match_confidence
);

  logic             skid_valid;
  npc_pkg::result_t skid;
  npc_pkg::result_t out_r;
  npc_pkg::result_t pipe_r;
  logic [npc_pkg::Q_W-1:0] q_clamp;
  logic             out_free;
  logic             load_pipe;

  always_comb begin
    q_clamp        = (root.q > npc_pkg::FULL_SCALE) ? npc_pkg::FULL_SCALE : root.q;
    pipe_r.idx     = root.idx;
    pipe_r.sq_dist = root.sq_dist;
    pipe_r.conf    = npc_pkg::FULL_SCALE - q_clamp;
  end

  assign en        = !skid_valid;
  assign out_free  = !out_valid || !out_stall;
  assign load_pipe = root.valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load_pipe;
      end
    end else if (load_pipe) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_r <= skid;
      end else if (load_pipe) begin
        out_r <= pipe_r;
      end
    end else if (load_pipe) begin
      skid <= pipe_r;
    end
  end

  assign match_index          = out_r.idx;
  assign min_distance_squared = out_r.sq_dist;
  assign match_confidence     = out_r.conf;

  // the skid stage only fills behind a stalled output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with no output word");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && skid_valid) |=> (out_valid && !skid_valid))
    else $error("skid word not moved to output");

  a_full_conf_exact: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_r.conf == npc_pkg::FULL_SCALE) == (out_r.sq_dist == '0)))
    else $error("full confidence does not match zero distance");

endmodule

@@ rtl/nearest_palette_color_classifier.sv @@
// top level of the nearest palette color classifier with its register port
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  in       | in_valid / in_stall     | sample_red, sample_green, sample_blue
//  out      | out_valid / out_stall   | match_index, min_distance_squared, match_confidence
//  cfg      | psel penable pwrite     | paddr, pwdata, prdata (palette entry i at 4*i)
//
//  one word enters per cycle while in_stall is low; it passes the distance registers,
//  the minimum tree, the seed register, the square root bit stages and the output register
//  reset restores the default palette and empties the pipeline, no clearing pass
//  in_stall rises only when the output word is stalled and the skid word is full;
//  the whole pipeline then holds until the skid word moves out
module nearest_palette_color_classifier #(
  parameter int PALETTE_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  sample_red,
  input  logic [7:0]  sample_green,
  input  logic [7:0]  sample_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  match_index,
  output logic [17:0] min_distance_squared,
  output logic [15:0] match_confidence,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  npc_pkg::palette_t  palette;
  npc_pkg::idx_t      reg_idx;
  logic               en;
  logic               dist_valid;
  npc_pkg::dist_vec_t sq_dist;
  logic               best_valid;
  npc_pkg::cand_t     best;
  npc_pkg::root_t     root;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign prdata  = {8'd0, palette[reg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      palette <= npc_pkg::RESET_PALETTE;
    end else if (psel && penable && pwrite && pready) begin
      palette[reg_idx] <= pwdata[23:0];
    end
  end

  assign in_stall = !en;

  npc_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .red        (sample_red),
    .green      (sample_green),
    .blue       (sample_blue),
    .palette    (palette),
    .dist_valid (dist_valid),
    .sq_dist    (sq_dist)
  );

  npc_min #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_min (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .dist_valid (dist_valid),
    .sq_dist    (sq_dist),
    .best_valid (best_valid),
    .best       (best)
  );

  npc_root u_root (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .best_valid (best_valid),
    .best       (best),
    .root       (root)
  );

  npc_out u_out (
    .clk                  (clk),
    .rst                  (rst),
    .root                 (root),
    .out_stall            (out_stall),
    .en                   (en),
    .out_valid            (out_valid),
    .match_index          (match_index),
    .min_distance_squared (min_distance_squared),
    .match_confidence     (match_confidence)
  );

endmodule

@@ bench/tb_nearest_palette_color_classifier.sv @@
// self-checking testbench for the nearest palette color classifier
module tb_nearest_palette_color_classifier;

  localparam int PAL_SIZE  = 8;
  localparam int LONG_HOLD = 300;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;
  typedef enum logic [2:0] {
    PAL_RESET, PAL_BLACK, PAL_WHITE, PAL_RANDOM, PAL_DUPS, PAL_CHECKER, PAL_EXTREME_MIX
  } pal_scheme_t;

  typedef struct {
    row_kind_t         kind;
    npc_pkg::idx_t     entry;
    logic [31:0]       color;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    bit                typed;
    npc_pkg::result_t  want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  sample_red = '0;
  logic [7:0]  sample_green = '0;
  logic [7:0]  sample_blue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  match_index;
  logic [17:0] min_distance_squared;
  logic [15:0] match_confidence;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [npc_pkg::COLOR_W-1:0] palette_model [npc_pkg::NUM_ENTRIES];
  npc_pkg::result_t            expected_matches [$];
  npc_pkg::result_t            front_match;
  int                          mismatch_count = 0;
  int                          burst_left = 0;
  int                          gap_max = 0;
  bit                          hold_request = 1'b0;
  int                          rx_mode = 0;
  int                          rx_left = 0;

  // directed words: palette colors hit exactly, far corners, ties between entries
  row_t dir_rows [27] = '{
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd0,   8'd0,   8'd0,   1'b1, '{3'd6, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd255, 8'd255, 8'd255, 1'b1, '{3'd7, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd255, 8'd255, 8'd0,   1'b1, '{3'd0, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd250, 8'd130, 8'd20,  1'b1, '{3'd1, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd255, 8'd0,   8'd0,   1'b1, '{3'd2, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd128, 8'd0,   8'd128, 1'b1, '{3'd3, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd0,   8'd0,   8'd255, 1'b1, '{3'd4, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd25,  8'd178, 8'd25,  1'b1, '{3'd5, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd170, 8'd85,  8'd170, 1'b0, '0},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd85,  8'd170, 8'd85,  1'b0, '0},
    // all entries black, upper data bits set on some writes
    '{ROW_CFG, 3'd0, 32'hFF000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd1, 32'h00000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd2, 32'h00000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd3, 32'h5A000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd4, 32'h00000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd5, 32'h00000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd6, 32'h00000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd7, 32'hA5000000, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd255, 8'd255, 8'd255, 1'b1, '{3'd0, 18'd195075, 16'h0000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd0,   8'd0,   8'd0,   1'b1, '{3'd0, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd1,   8'd0,   8'd0,   1'b0, '0},
    // two identical gray entries, equidistant sample goes to the lower one, entry two
    '{ROW_CFG, 3'd2, 32'hFF808080, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_CFG, 3'd5, 32'h00808080, 8'd0, 8'd0, 8'd0, 1'b0, '0},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd64,  8'd64,  8'd64,  1'b0, '0},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd128, 8'd128, 8'd128, 1'b1, '{3'd2, 18'd0, 16'h8000}},
    '{ROW_SAMPLE, 3'd0, 32'h0, 8'd129, 8'd128, 8'd128, 1'b0, '0}
  };

  pal_scheme_t phase_schemes [8] = '{
    PAL_RESET, PAL_RANDOM, PAL_BLACK, PAL_DUPS, PAL_WHITE, PAL_CHECKER, PAL_EXTREME_MIX,
    PAL_RANDOM
  };

  nearest_palette_color_classifier #(.PALETTE_SIZE(PAL_SIZE)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_red(sample_red), .sample_green(sample_green), .sample_blue(sample_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .match_index(match_index), .min_distance_squared(min_distance_squared),
    .match_confidence(match_confidence),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // round(32768 * sqrt(dist / max)) found bit by bit, then taken from full scale
  function automatic logic [npc_pkg::CONF_W-1:0] confidence_q15(input int unsigned sq_dist);
    longint unsigned target;
    longint unsigned odd;
    int unsigned     root;
    int unsigned     trial;
    target = longint'(sq_dist) << 32;
    root = 0;
    for (int k = 15; k >= 0; k--) begin
      trial = root | (32'd1 << k);
      odd = 2 * longint'(trial) - 1;
      if (odd * odd * longint'(npc_pkg::MAX_DIST) <= target) root = trial;
    end
    if (root > 32768) root = 32768;
    return npc_pkg::CONF_W'(32768 - root);
  endfunction

  function automatic npc_pkg::result_t nearest_entry(input logic [7:0] r, g, b);
    npc_pkg::result_t best;
    int               dr;
    int               dg;
    int               db;
    int               d;
    best = '0;
    for (int i = 0; i < PAL_SIZE; i++) begin
      dr = int'(r) - int'(palette_model[i][23:16]);
      dg = int'(g) - int'(palette_model[i][15:8]);
      db = int'(b) - int'(palette_model[i][7:0]);
      d = dr * dr + dg * dg + db * db;
      if (i == 0 || d < int'(best.sq_dist)) begin
        best.sq_dist = npc_pkg::dist_t'(d);
        best.idx = npc_pkg::idx_t'(i);
      end
    end
    best.conf = confidence_q15(best.sq_dist);
    return best;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic send_sample(input logic [7:0] r, g, b, input bit typed,
                             input npc_pkg::result_t typed_match);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample_red <= r;
    sample_green <= g;
    sample_blue <= b;
    do @(posedge clk); while (in_stall);
    expected_matches.push_back(typed ? typed_match : nearest_entry(r, g, b));
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
  endtask

  task automatic write_palette(input npc_pkg::idx_t entry, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {entry, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    palette_model[entry] = value[npc_pkg::COLOR_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_palette(input pal_scheme_t scheme);
    logic [npc_pkg::COLOR_W-1:0] pool [3];
    logic [npc_pkg::COLOR_W-1:0] color;
    foreach (pool[k]) pool[k] = npc_pkg::COLOR_W'($urandom);
    for (int i = 0; i < npc_pkg::NUM_ENTRIES; i++) begin
      case (scheme)
        PAL_RESET:   color = npc_pkg::RESET_PALETTE[i];
        PAL_BLACK:   color = '0;
        PAL_WHITE:   color = '1;
        PAL_DUPS:    color = pool[$urandom_range(0, 2)];
        PAL_CHECKER: color = i[0] ? '1 : '0;
        PAL_EXTREME_MIX: begin
          for (int c = 0; c < 3; c++) begin
            case ($urandom_range(0, 2))
              0: color[8*c +: 8] = 8'h00;
              1: color[8*c +: 8] = 8'hFF;
              default: color[8*c +: 8] = 8'($urandom);
            endcase
          end
        end
        default:     color = npc_pkg::COLOR_W'($urandom);
      endcase
      write_palette(npc_pkg::idx_t'(i), {8'($urandom), color});
    end
  endtask

  task automatic run_random_phase(input int count);
    logic [7:0] ch [3];
    int         e;
    int         f;
    int         v;
    for (int n = 0; n < count; n++) begin
      e = $urandom_range(0, npc_pkg::NUM_ENTRIES - 1);
      f = $urandom_range(0, npc_pkg::NUM_ENTRIES - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: foreach (ch[c]) ch[c] = 8'($urandom);
        4, 5, 6: begin
          // close to an entry, clamped at the channel limits
          foreach (ch[c]) begin
            v = int'(palette_model[e][8*(2-c) +: 8]) + $urandom_range(0, 6) - 3;
            ch[c] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
          end
        end
        7: foreach (ch[c]) begin
          // halfway between two entries, often an exact tie
          ch[c] = 8'((int'(palette_model[e][8*(2-c) +: 8]) +
                      int'(palette_model[f][8*(2-c) +: 8])) / 2);
        end
        default: foreach (ch[c]) ch[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_sample(ch[0], ch[1], ch[2], 1'b0, '0);
    end
  endtask

  // receiver: stall pattern changes now and then, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // compare every word leaving the block with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected word, expected none actual idx=%0d dist=%0d conf=%0d",
                 $time, match_index, min_distance_squared, match_confidence);
        mismatch_count++;
      end else begin
        front_match = expected_matches.pop_front();
        check_field("match_index", front_match.idx, match_index);
        check_field("min_distance_squared", front_match.sq_dist, min_distance_squared);
        check_field("match_confidence", front_match.conf, match_confidence);
      end
    end
  end

  initial begin
    foreach (palette_model[i]) palette_model[i] = npc_pkg::RESET_PALETTE[i];
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_max = 4;
    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        wait_for_idle();
        write_palette(dir_rows[n].entry, dir_rows[n].color);
      end else begin
        send_sample(dir_rows[n].red, dir_rows[n].green, dir_rows[n].blue,
                    dir_rows[n].typed, dir_rows[n].want);
      end
    end

    foreach (phase_schemes[p]) begin
      wait_for_idle();
      load_palette(phase_schemes[p]);
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
      if (p == 3) begin
        // back up the pipeline while words keep coming, then let it run dry
        hold_request = 1'b1;
        gap_max = 0;
        run_random_phase(120);
        wait_for_idle();
        gap_max = 5;
        run_random_phase(110);
      end else begin
        run_random_phase(230);
      end
    end

    wait_for_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
